// File: rtl/core/flr_pkg.sv
// ----------------------------------------------------------------------------
// flr_pkg
// Shared types and constants of the line rasterizer.
// ----------------------------------------------------------------------------
package flr_pkg;

	localparam int CoordW = 13;
	localparam int PixelW = 32;
	localparam int RegW   = 9;
	localparam int IdxW   = 1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LINE  = 2'd1,
		OP_TRI   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	localparam logic [IdxW-1:0] REG_WIDTH  = 1'b0;
	localparam logic [IdxW-1:0] REG_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SETUP,
		ST_DIV,
		ST_STEP,
		ST_RD_WAIT,
		ST_RD_DATA,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [PixelW-1:0] read_data;
		logic              was_read;
	} result_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [CoordW-1:0] x0;
		logic [CoordW-1:0] y0;
		logic [CoordW-1:0] x1;
		logic [CoordW-1:0] y1;
		logic [CoordW-1:0] x2;
		logic [CoordW-1:0] y2;
		logic [PixelW-1:0] colour;
	} cmd_t;

endpackage

// File: rtl/core/flr_if.sv
// ----------------------------------------------------------------------------
// flr_cmd_if / flr_res_if
// Valid/ready channels carrying command and result beats.
// ----------------------------------------------------------------------------
interface flr_cmd_if import flr_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface flr_res_if import flr_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/flr_div.sv
// ----------------------------------------------------------------------------
// flr_div
// Restoring divider: signed 30-bit numerator over unsigned 14-bit divisor,
// one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module flr_div import flr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [29:0] num,
	input  logic [13:0] den,
	output logic        busy,
	output logic [29:0] quo
);
	logic [28:0] mag_q;
	logic [28:0] q_q;
	logic [14:0] rem_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic [13:0] den_q;
	logic [14:0] trial;
	logic [14:0] diff;

	assign trial = {rem_q[13:0], mag_q[28]};
	assign diff  = trial - {1'b0, den_q};

	// shift in one numerator bit, subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 5'd29;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[29];
			mag_q <= num[29] ? 29'(-num) : num[28:0];
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy) begin
			mag_q <= {mag_q[27:0], 1'b0};
			if (!diff[14]) begin
				rem_q <= diff;
				q_q   <= {q_q[27:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[27:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -{1'b0, q_q} : {1'b0, q_q};
endmodule

// File: rtl/core/framebuffer_line_rasterizer.sv
// ----------------------------------------------------------------------------
// framebuffer_line_rasterizer
// Frame store with clear, DDA line, triangle and pixel read commands.
// ----------------------------------------------------------------------------
// Commands enter on cmd (valid/ready); each gives exactly one result beat on
// res. Configuration writes (cfg_we, cfg_index, cfg_data) set the active
// width (row pitch) and height; values above MAX_WIDTH/MAX_HEIGHT saturate.
// One command is worked at a time; a finished result sits in an output
// register, so the next command is taken while the result waits.
// Work after the accepting edge, bounded by the single store write port and the
// serial divider (one quotient bit per cycle, two divisions per edge):
//   clear:    one store write per pixel of width*height (none for an empty area), then done
//   line:     setup, x and y divide (skipped for len 0), len+1 pixel steps, then done
//   triangle: setup, divide and pixel steps of every triangle edge in turn, then done
//   read:     ST_RD_WAIT registers the store word, ST_RD_DATA loads the result
// The block is ready again in the cycle after the result is loaded.
// Reset sets width and height to 256; the store content is undefined until a
// clear. When res stalls, the block takes one more command, works it, and
// holds in its last cycle until the output register frees.
// ----------------------------------------------------------------------------
module framebuffer_line_rasterizer import flr_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	flr_cmd_if.sink             cmd,
	flr_res_if.source           res,
	input  logic                cfg_we,
	input  logic [IdxW-1:0]     cfg_index,
	input  logic [RegW-1:0]     cfg_data
);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

	logic [RegW-1:0] width_q, height_q;
	logic [13:0]     ew, eh;
	state_t          state_q, state_d;

	cmd_t            c_q;
	logic [1:0]      edge_q;
	logic [13:0]     ax0, ay0, ax1, ay1;
	logic [13:0]     dx, dy, adx, ady, len;
	logic [13:0]     len_q, cnt_q;
	logic [31:0]     px_q, py_q;
	logic [29:0]     ix_q, iy_q;
	logic            div_y_q;
	logic [12:0]     cx_q, cy_q;

	logic            div_start, div_busy;
	logic [29:0]     div_num, div_quo;

	logic [PixelW-1:0] mem [DEPTH];
	logic [PixelW-1:0] rd_s1;
	logic              we;
	logic [AW-1:0]     waddr, raddr;

	logic [31:0]     rx, ry;
	logic            rx_in, ry_in;
	logic            res_full_q;
	logic            res_load;
	result_t         res_q;

	// saturate the active area to the store size
	assign ew = (14'(width_q) > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : 14'(width_q);
	assign eh = (14'(height_q) > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : 14'(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// select the current edge endpoints
	always_comb begin
		case (edge_q)
			2'd0: begin
				ax0 = 14'(signed'(c_q.x0)); ay0 = 14'(signed'(c_q.y0));
				ax1 = 14'(signed'(c_q.x1)); ay1 = 14'(signed'(c_q.y1));
			end
			2'd1: begin
				ax0 = 14'(signed'(c_q.x1)); ay0 = 14'(signed'(c_q.y1));
				ax1 = 14'(signed'(c_q.x2)); ay1 = 14'(signed'(c_q.y2));
			end
			default: begin
				ax0 = 14'(signed'(c_q.x2)); ay0 = 14'(signed'(c_q.y2));
				ax1 = 14'(signed'(c_q.x0)); ay1 = 14'(signed'(c_q.y0));
			end
		endcase
	end

	assign dx  = ax1 - ax0;
	assign dy  = ay1 - ay0;
	assign adx = dx[13] ? -dx : dx;
	assign ady = dy[13] ? -dy : dy;
	assign len = (adx >= ady) ? adx : ady;

	// x increment starts from setup, y increment from the divide state
	assign div_num = (state_q == ST_DIV) ? {dy, 16'd0} : {dx, 16'd0};

	flr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (len),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// round half away from zero
	function automatic logic [31:0] rnd(input logic [31:0] p);
		logic [31:0] m;
		logic [31:0] r;
		m = p[31] ? -p : p;
		r = (m + 32'h8000) >> 16;
		return p[31] ? -r : r;
	endfunction

	assign rx = rnd(px_q);
	assign ry = rnd(py_q);
	assign rx_in = !rx[31] && (rx < 32'(ew));
	assign ry_in = !ry[31] && (ry < 32'(eh));

	// load the output register when it is free or being drained
	assign res_load = (state_q == ST_DONE || state_q == ST_RD_DATA) &&
	                  (!res_full_q || res.ready);

	// next state
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		cmd.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					case (op_t'(cmd.data.opcode))
						OP_CLEAR: state_d = ST_CLEAR;
						OP_READ:  state_d = ST_RD_WAIT;
						default:  state_d = ST_SETUP;
					endcase
				end
			end
			ST_CLEAR: begin
				if (ew == 14'd0 || eh == 14'd0 ||
				    (14'(cx_q) == ew - 14'd1 && 14'(cy_q) == eh - 14'd1))
					state_d = ST_DONE;
			end
			ST_SETUP: begin
				if (len == 14'd0) state_d = ST_STEP;
				else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!div_busy) begin
					if (!div_y_q) begin
						div_start = 1'b1;
					end else state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (cnt_q == len_q) begin
					if (op_t'(c_q.opcode) == OP_TRI && edge_q != 2'd2) state_d = ST_SETUP;
					else state_d = ST_DONE;
				end
			end
			ST_RD_WAIT: state_d = ST_RD_DATA;
			ST_RD_DATA: if (res_load) state_d = ST_IDLE;
			ST_DONE:    if (res_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q  <= '0;
			div_y_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					edge_q  <= '0;
					div_y_q <= 1'b0;
				end
				ST_SETUP: div_y_q <= 1'b0;
				ST_DIV: if (!div_busy && !div_y_q) div_y_q <= 1'b1;
				ST_STEP: if (cnt_q == len_q) edge_q <= edge_q + 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				c_q  <= cmd.data;
				cx_q <= '0;
				cy_q <= '0;
			end
			ST_CLEAR: begin
				if (14'(cx_q) == ew - 14'd1) begin
					cx_q <= '0;
					cy_q <= cy_q + 13'd1;
				end else cx_q <= cx_q + 13'd1;
			end
			ST_SETUP: begin
				len_q <= len;
				cnt_q <= '0;
				px_q  <= {{3{ax0[13]}}, ax0[12:0], 16'd0};
				py_q  <= {{3{ay0[13]}}, ay0[12:0], 16'd0};
				ix_q  <= '0;
				iy_q  <= '0;
			end
			ST_DIV: begin
				if (!div_busy) begin
					if (!div_y_q) ix_q <= div_quo;
					else          iy_q <= div_quo;
				end
			end
			ST_STEP: begin
				cnt_q <= cnt_q + 14'd1;
				px_q  <= px_q + 32'(signed'(ix_q));
				py_q  <= py_q + 32'(signed'(iy_q));
			end
			default: ;
		endcase
	end

	// store write port: clear sweep or drawn pixel
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		if (state_q == ST_CLEAR && ew != 14'd0 && eh != 14'd0) begin
			we    = 1'b1;
			waddr = AW'(32'(cy_q) * 32'(ew) + 32'(cx_q));
		end else if (state_q == ST_STEP && rx_in && ry_in) begin
			we    = 1'b1;
			waddr = AW'(ry * 32'(ew) + rx);
		end
	end

	assign raddr = AW'(32'(c_q.y0[11:0]) * 32'(ew) + 32'(c_q.x0[11:0]));

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= c_q.colour;
		rd_s1 <= mem[raddr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_full_q <= 1'b0;
		else if (res_load) res_full_q <= 1'b1;
		else if (res.ready) res_full_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load && state_q == ST_DONE) begin
			res_q.read_data <= '0;
			res_q.was_read  <= 1'b0;
		end else if (res_load) begin
			res_q.was_read  <= 1'b1;
			res_q.read_data <= (!c_q.x0[12] && !c_q.y0[12] &&
			                    14'(c_q.x0) < ew && 14'(c_q.y0) < eh) ? rd_s1 : '0;
		end
	end

	assign res.valid = res_full_q;
	assign res.data  = res_q;
endmodule

// File: rtl/core/flr_checker.sv
// ----------------------------------------------------------------------------
// flr_checker
// Port-level checks on the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module flr_checker import flr_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    cmd_valid,
	input logic    cmd_ready,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res_data
);
	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped under stall");

	// one command at a time: drop ready after a command beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second command taken while busy");

	// non-read results carry zero data
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.was_read |-> res_data.read_data == '0)
		else $error("non-read result with data");

	// handshake outputs are always driven
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({cmd_ready, res_valid}))
		else $error("unknown handshake output");
endmodule

bind framebuffer_line_rasterizer flr_checker u_flr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
